@@ sv/hvd_pkg.sv @@
// Shared constants and types for the haversine distance pipeline.
package hvd_pkg;

	localparam int unsigned ITERS     = 30;
	localparam int unsigned SQ_STEPS  = 31;
	localparam int unsigned LANES     = 4;

	// Lane roles in the angle and rotation sections
	localparam int unsigned LN_DLAT = 0;
	localparam int unsigned LN_DLON = 1;
	localparam int unsigned LN_LATA = 2;
	localparam int unsigned LN_LATB = 3;

	localparam logic [31:0]        UNITS_TURN = 32'd3600000000;
	localparam logic [31:0]        HALF_TURN  = 32'd1800000000;
	localparam logic signed [34:0] TURN_W     = 35'sd3600000000;
	localparam logic signed [34:0] TURN2_W    = 35'sd7200000000;
	localparam logic signed [33:0] GAIN_Q30   = 34'sd652032874;
	localparam logic [60:0]        ONE_Q60    = {1'b1, 60'd0};
	localparam logic [30:0]        DIST_SCALE = 31'd1281327466;
	localparam logic [24:0]        DIST_MAX   = 25'd20022000;

	// floor(2^63 / one turn), reciprocal for the angle scaling
	localparam logic [31:0]        DIV_RECIP  = 32'd2562047788;
	// One, two and three turns for the quotient correction
	localparam logic [34:0]        REM_1T     = 35'd3600000000;
	localparam logic [34:0]        REM_2T     = 35'd7200000000;
	localparam logic [34:0]        REM_3T     = 35'd10800000000;

	typedef logic signed [33:0] cw_t;
	typedef logic signed [32:0] ang_t;

	// Arctangent of 2^-i as a binary angle, 2^32 per turn
	localparam logic [29:0] ATAN_TAB [0:ITERS-1] = '{
		30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
		30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
		30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
		30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
		30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
		30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
	};

endpackage

@@ sv/haversine_distance_unit.sv @@
// Throughput: one point pair per cycle unless stalled; the 106 pipeline stages (angle scaling,
// CORDIC rotation, three multiplies, two square roots, CORDIC vectoring) all advance together.
// A stall holds the whole pipeline only when the last stage and the output register are both full.
// Reset (arst_n low) clears all valid bits at once; data registers are not reset.
// Top level: haversine great-circle distance, fully pipelined.
module haversine_distance_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// lat_a [30:0], lon_a [62:31], lat_b [93:63], lon_b [125:94], zero pad [127:126]
	input  logic [127:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// distance_m [24:0], zero pad [31:25]
	output logic [31:0]  m_axis_tdata
);
	import hvd_pkg::*;

	logic adv;

	// Input fields
	logic signed [30:0] lat_a, lat_b;
	logic signed [31:0] lon_a, lon_b;
	assign lat_a = s_axis_tdata[30:0];
	assign lon_a = s_axis_tdata[62:31];
	assign lat_b = s_axis_tdata[93:63];
	assign lon_b = s_axis_tdata[125:94];

	// Stage 1: differences
	logic               v_s1;
	logic signed [31:0] dlat_s1;
	logic signed [32:0] dlon_s1;
	logic signed [30:0] lata_s1, latb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dlat_s1 <= {lat_b[30], lat_b} - {lat_a[30], lat_a};
			dlon_s1 <= {lon_b[31], lon_b} - {lon_a[31], lon_a};
			lata_s1 <= lat_a;
			latb_s1 <= lat_b;
		end
	end

	// Stage 2: reduce to one turn, candidates in parallel
	logic               v_s2;
	logic [31:0]        u_s2 [0:LANES-1];
	logic [31:0]        red  [0:LANES-1];
	logic signed [34:0] lon_d, lon_p1, lon_p2, lon_m1, dlat_w, lata_w, latb_w;

	always_comb begin
		lon_d  = {{2{dlon_s1[32]}}, dlon_s1};
		lon_p1 = lon_d + TURN_W;
		lon_p2 = lon_d + TURN2_W;
		lon_m1 = lon_d - TURN_W;
		dlat_w = {{3{dlat_s1[31]}}, dlat_s1};
		lata_w = {{4{lata_s1[30]}}, lata_s1};
		latb_w = {{4{latb_s1[30]}}, latb_s1};
		if (lon_d[34]) begin
			red[LN_DLON] = lon_p1[34] ? lon_p2[31:0] : lon_p1[31:0];
		end else if (!lon_m1[34]) begin
			red[LN_DLON] = lon_m1[31:0];
		end else begin
			red[LN_DLON] = lon_d[31:0];
		end
		red[LN_DLAT] = dlat_w[34] ? 32'(dlat_w + TURN_W) : dlat_w[31:0];
		red[LN_LATA] = lata_w[34] ? 32'(lata_w + TURN_W) : lata_w[31:0];
		red[LN_LATB] = latb_w[34] ? 32'(latb_w + TURN_W) : latb_w[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s2 <= red;
		end
	end

	// Angle scaling: round(u * 2^k / turn) by reciprocal multiply, then a small correction.
	// Full angles use k = 32, half angles k = 31; the estimate is low by at most three.
	logic        v_s3, v_s4, v_s5;
	logic [63:0] div_num0   [0:LANES-1];
	logic [63:0] div_p_s3   [0:LANES-1];
	logic [63:0] div_num_s3 [0:LANES-1];
	logic [31:0] div_q0     [0:LANES-1];
	logic [31:0] div_q0_s4  [0:LANES-1];
	logic [63:0] div_qd_s4  [0:LANES-1];
	logic [63:0] div_num_s4 [0:LANES-1];
	logic [63:0] div_dif    [0:LANES-1];
	logic [34:0] div_rem    [0:LANES-1];
	logic [31:0] div_q      [0:LANES-1];
	logic [31:0] ang_s5     [0:LANES-1];

	always_comb begin
		// Numerator u*2^k plus half a turn for rounding
		for (int l = 0; l < LANES; l++) begin
			if (l == LN_DLAT || l == LN_DLON) begin
				div_num0[l] = {1'b0, u_s2[l], HALF_TURN[30:0]};
			end else begin
				div_num0[l] = {u_s2[l], HALF_TURN};
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (l == LN_DLAT || l == LN_DLON) begin
				div_q0[l] = div_p_s3[l][63:32];
			end else begin
				div_q0[l] = div_p_s3[l][62:31];
			end
		end
	end

	always_comb begin
		// Add back the whole turns left in the remainder
		for (int l = 0; l < LANES; l++) begin
			div_dif[l] = div_num_s4[l] - div_qd_s4[l];
			div_rem[l] = div_dif[l][34:0];
			if (div_rem[l] >= REM_3T) begin
				div_q[l] = div_q0_s4[l] + 32'd3;
			end else if (div_rem[l] >= REM_2T) begin
				div_q[l] = div_q0_s4[l] + 32'd2;
			end else if (div_rem[l] >= REM_1T) begin
				div_q[l] = div_q0_s4[l] + 32'd1;
			end else begin
				div_q[l] = div_q0_s4[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				div_p_s3[l]   <= 64'(u_s2[l]) * 64'(DIV_RECIP);
				div_num_s3[l] <= div_num0[l];
				div_q0_s4[l]  <= div_q0[l];
				div_qd_s4[l]  <= 64'(div_q0[l]) * 64'(UNITS_TURN);
				div_num_s4[l] <= div_num_s3[l];
				ang_s5[l]     <= div_q[l];
			end
		end
	end

	// CORDIC rotation for sine and cosine, one iteration per stage
	logic [ITERS:0] rot_v_s;
	cw_t  rot_x_s [0:ITERS][0:LANES-1];
	cw_t  rot_y_s [0:ITERS][0:LANES-1];
	ang_t rot_z_s [0:ITERS][0:LANES-1];
	logic rot_f_s [0:ITERS][0:LANES-1];
	cw_t  rot_xn  [0:ITERS-1][0:LANES-1];
	cw_t  rot_yn  [0:ITERS-1][0:LANES-1];
	ang_t rot_zn  [0:ITERS-1][0:LANES-1];
	ang_t rot_z0  [0:LANES-1];
	logic rot_f0  [0:LANES-1];
	logic [31:0] ang_in;

	always_comb begin
		ang_in = '0;
		// Fold the second and third quadrants by half a turn
		for (int l = 0; l < LANES; l++) begin
			ang_in    = ang_s5[l];
			rot_f0[l] = ang_in[31] ^ ang_in[30];
			rot_z0[l] = {ang_in[30], ang_in[30], ang_in[30:0]};
		end
	end

	always_comb begin
		for (int k = 0; k < ITERS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				if (!rot_z_s[k][l][32]) begin
					rot_xn[k][l] = rot_x_s[k][l] - (rot_y_s[k][l] >>> k);
					rot_yn[k][l] = rot_y_s[k][l] + (rot_x_s[k][l] >>> k);
					rot_zn[k][l] = rot_z_s[k][l] - $signed({3'b0, ATAN_TAB[k]});
				end else begin
					rot_xn[k][l] = rot_x_s[k][l] + (rot_y_s[k][l] >>> k);
					rot_yn[k][l] = rot_y_s[k][l] - (rot_x_s[k][l] >>> k);
					rot_zn[k][l] = rot_z_s[k][l] + $signed({3'b0, ATAN_TAB[k]});
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_v_s <= '0;
		end else if (adv) begin
			rot_v_s <= {rot_v_s[ITERS-1:0], v_s5};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				rot_x_s[0][l] <= GAIN_Q30;
				rot_y_s[0][l] <= '0;
				rot_z_s[0][l] <= rot_z0[l];
				rot_f_s[0][l] <= rot_f0[l];
			end
			for (int k = 0; k < ITERS; k++) begin
				rot_x_s[k+1] <= rot_xn[k];
				rot_y_s[k+1] <= rot_yn[k];
				rot_z_s[k+1] <= rot_zn[k];
				rot_f_s[k+1] <= rot_f_s[k];
			end
		end
	end

	// Trig results, undo the quadrant fold
	logic v_s37;
	cw_t  sa_s37, sb_s37, ca_s37, cb_s37;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s37 <= 1'b0;
		end else if (adv) begin
			v_s37 <= rot_v_s[ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_s37 <= rot_f_s[ITERS][LN_DLAT] ? -rot_y_s[ITERS][LN_DLAT]
			                                  :  rot_y_s[ITERS][LN_DLAT];
			sb_s37 <= rot_f_s[ITERS][LN_DLON] ? -rot_y_s[ITERS][LN_DLON]
			                                  :  rot_y_s[ITERS][LN_DLON];
			ca_s37 <= rot_f_s[ITERS][LN_LATA] ? -rot_x_s[ITERS][LN_LATA]
			                                  :  rot_x_s[ITERS][LN_LATA];
			cb_s37 <= rot_f_s[ITERS][LN_LATB] ? -rot_x_s[ITERS][LN_LATB]
			                                  :  rot_x_s[ITERS][LN_LATB];
		end
	end

	// Haversine term: three multiply stages and a clamped sum
	logic               v_s38, v_s39, v_s40, v_s41;
	logic signed [67:0] p_s38, sa2_s38, sa2_s39, sa2_s40, up_s39, v_s40_p;
	cw_t                sb_s38, sb_s39;
	logic signed [67:0] hsum;
	logic [60:0]        hn, h_s41;

	always_comb begin
		hsum = sa2_s40 + v_s40_p;
		if (hsum[67]) begin
			hn = '0;
		end else if (hsum > $signed({7'd0, ONE_Q60})) begin
			hn = ONE_Q60;
		end else begin
			hn = hsum[60:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s38 <= 1'b0;
			v_s39 <= 1'b0;
			v_s40 <= 1'b0;
			v_s41 <= 1'b0;
		end else if (adv) begin
			v_s38 <= v_s37;
			v_s39 <= v_s38;
			v_s40 <= v_s39;
			v_s41 <= v_s40;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s38   <= 68'(ca_s37) * 68'(cb_s37);
			sa2_s38 <= 68'(sa_s37) * 68'(sa_s37);
			sb_s38  <= sb_s37;
			up_s39  <= 68'($signed(p_s38[63:30])) * 68'(sb_s38);
			sa2_s39 <= sa2_s38;
			sb_s39  <= sb_s38;
			v_s40_p <= 68'($signed(up_s39[63:30])) * 68'(sb_s39);
			sa2_s40 <= sa2_s39;
			h_s41   <= hn;
		end
	end

	// Two square roots, one result bit per stage
	logic [SQ_STEPS:0] sq_v_s;
	logic [61:0] sq_n_s    [0:SQ_STEPS][0:1];
	logic [32:0] sq_rem_s  [0:SQ_STEPS][0:1];
	logic [30:0] sq_root_s [0:SQ_STEPS][0:1];
	logic [61:0] sq_nn     [0:SQ_STEPS-1][0:1];
	logic [32:0] sq_remn   [0:SQ_STEPS-1][0:1];
	logic [30:0] sq_rootn  [0:SQ_STEPS-1][0:1];
	logic [34:0] srs, strial, sdiff;

	always_comb begin
		srs    = '0;
		strial = '0;
		sdiff  = '0;
		for (int k = 0; k < SQ_STEPS; k++) begin
			for (int r = 0; r < 2; r++) begin
				srs    = {sq_rem_s[k][r], sq_n_s[k][r][61:60]};
				strial = {2'b0, sq_root_s[k][r], 2'b01};
				sdiff  = srs - strial;
				sq_nn[k][r] = {sq_n_s[k][r][59:0], 2'b00};
				if (!sdiff[34]) begin
					sq_remn[k][r]  = sdiff[32:0];
					sq_rootn[k][r] = {sq_root_s[k][r][29:0], 1'b1};
				end else begin
					sq_remn[k][r]  = srs[32:0];
					sq_rootn[k][r] = {sq_root_s[k][r][29:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s <= '0;
		end else if (adv) begin
			sq_v_s <= {sq_v_s[SQ_STEPS-1:0], v_s41};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_n_s[0][0]    <= {1'b0, h_s41};
			sq_n_s[0][1]    <= {1'b0, ONE_Q60 - h_s41};
			sq_rem_s[0][0]  <= '0;
			sq_rem_s[0][1]  <= '0;
			sq_root_s[0][0] <= '0;
			sq_root_s[0][1] <= '0;
			for (int k = 0; k < SQ_STEPS; k++) begin
				sq_n_s[k+1]    <= sq_nn[k];
				sq_rem_s[k+1]  <= sq_remn[k];
				sq_root_s[k+1] <= sq_rootn[k];
			end
		end
	end

	// CORDIC vectoring: angle of (c, s)
	logic [ITERS:0] vec_v_s;
	cw_t  vec_x_s [0:ITERS];
	cw_t  vec_y_s [0:ITERS];
	ang_t vec_z_s [0:ITERS];
	cw_t  vec_xn  [0:ITERS-1];
	cw_t  vec_yn  [0:ITERS-1];
	ang_t vec_zn  [0:ITERS-1];

	always_comb begin
		for (int k = 0; k < ITERS; k++) begin
			if (!vec_y_s[k][33]) begin
				vec_xn[k] = vec_x_s[k] + (vec_y_s[k] >>> k);
				vec_yn[k] = vec_y_s[k] - (vec_x_s[k] >>> k);
				vec_zn[k] = vec_z_s[k] + $signed({3'b0, ATAN_TAB[k]});
			end else begin
				vec_xn[k] = vec_x_s[k] - (vec_y_s[k] >>> k);
				vec_yn[k] = vec_y_s[k] + (vec_x_s[k] >>> k);
				vec_zn[k] = vec_z_s[k] - $signed({3'b0, ATAN_TAB[k]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_v_s <= '0;
		end else if (adv) begin
			vec_v_s <= {vec_v_s[ITERS-1:0], sq_v_s[SQ_STEPS]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_x_s[0] <= {3'b0, sq_root_s[SQ_STEPS][1]};
			vec_y_s[0] <= {3'b0, sq_root_s[SQ_STEPS][0]};
			vec_z_s[0] <= '0;
			for (int k = 0; k < ITERS; k++) begin
				vec_x_s[k+1] <= vec_xn[k];
				vec_y_s[k+1] <= vec_yn[k];
				vec_z_s[k+1] <= vec_zn[k];
			end
		end
	end

	// Scale angle to metres, round and saturate
	logic        v_s105, v_s106;
	logic [31:0] zc;
	logic [62:0] dp_s105;
	logic [63:0] dround;
	logic [27:0] dmet;
	logic [24:0] dd_s106;

	assign zc     = vec_z_s[ITERS][32] ? 32'd0 : vec_z_s[ITERS][31:0];
	assign dround = {1'b0, dp_s105} + 64'(36'h800000000);
	assign dmet   = dround[63:36];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s105 <= 1'b0;
			v_s106 <= 1'b0;
		end else if (adv) begin
			v_s105 <= vec_v_s[ITERS];
			v_s106 <= v_s105;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dp_s105 <= 63'(zc) * 63'(DIST_SCALE);
			dd_s106 <= (dmet > 28'(DIST_MAX)) ? DIST_MAX : dmet[24:0];
		end
	end

	// Output register; hold the pipeline only when it and the last stage are full
	logic        out_v_q;
	logic [24:0] dist_q;

	assign adv           = !(v_s106 && out_v_q && !m_axis_tready);
	assign s_axis_tready = adv;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'd0, dist_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			out_v_q <= v_s106;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			dist_q <= dd_s106;
		end
	end

	// Checks
	a_dist_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (dist_q <= DIST_MAX))
		else $error("distance above saturation limit");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> v_s1)
		else $error("accepted transfer did not enter stage 1");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |=> ($stable(vec_v_s) && $stable(sq_v_s) && $stable(rot_v_s)))
		else $error("pipeline moved during stall");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v_s[SQ_STEPS] |-> (sq_root_s[SQ_STEPS][0] <= {1'b1, 30'd0} &&
		                     sq_root_s[SQ_STEPS][1] <= {1'b1, 30'd0}))
		else $error("square root above one");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the haversine distance pipeline.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint UNITS_TURN_L = 64'sd3600000000;
	localparam longint HALF_TURN_L  = 64'sd1800000000;
	localparam longint GAIN_L       = 64'sd652032874;
	localparam longint ONE_Q60_L    = 64'sd1 << 60;
	localparam longint SCALE_L      = 64'sd1281327466;
	localparam longint DMAX_L       = 64'sd20022000;
	localparam int     WATCH_LIMIT  = 6000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [31:0]  m_axis_tdata;

	haversine_distance_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Reduce a difference in input units into one turn
	function automatic longint wrap_units(input longint d);
		longint r;
		r = d % UNITS_TURN_L;
		if (r < 0) r += UNITS_TURN_L;
		return r;
	endfunction

	// CORDIC rotation: sine and cosine of a binary angle in Q30
	function automatic void rotate_angle(input bit [31:0] a, output longint sn, output longint cs);
		bit     flip;
		longint x, y, z, dx, dy;
		flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
		if (flip) a = a + 32'h80000000;
		x = GAIN_L;
		y = 0;
		z = longint'($signed(a));
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(hvd_pkg::ATAN_TAB[i]);
			end else begin
				x += dx; y -= dy; z += longint'(hvd_pkg::ATAN_TAB[i]);
			end
		end
		sn = flip ? -y : y;
		cs = flip ? -x : x;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 60;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Great-circle distance in metres for one point pair
	function automatic logic [24:0] great_circle_m(input logic [127:0] pair);
		longint lat_a, lon_a, lat_b, lon_b;
		longint sa, sb, ca, cb, junk, t, u, h, z, x, y, dx, dy, d;
		longint unsigned w;
		bit [31:0] ang;
		lat_a = longint'($signed(pair[30:0]));
		lon_a = longint'($signed(pair[62:31]));
		lat_b = longint'($signed(pair[93:63]));
		lon_b = longint'($signed(pair[125:94]));
		w = longint'(wrap_units(lat_b - lat_a));
		ang = 32'(((w << 31) + HALF_TURN_L) / UNITS_TURN_L);
		rotate_angle(ang, sa, junk);
		w = longint'(wrap_units(lon_b - lon_a));
		ang = 32'(((w << 31) + HALF_TURN_L) / UNITS_TURN_L);
		rotate_angle(ang, sb, junk);
		w = longint'(wrap_units(lat_a));
		ang = 32'(((w << 32) + 64'd1800000000) / 64'd3600000000);
		rotate_angle(ang, junk, ca);
		w = longint'(wrap_units(lat_b));
		ang = 32'(((w << 32) + 64'd1800000000) / 64'd3600000000);
		rotate_angle(ang, junk, cb);
		t = (ca * cb) >>> 30;
		u = (t * sb) >>> 30;
		h = sa * sa + u * sb;
		if (h < 0) h = 0;
		if (h > ONE_Q60_L) h = ONE_Q60_L;
		// CORDIC vectoring of (cos, sin) of the half central angle
		y = longint'(int_sqrt(h));
		x = longint'(int_sqrt(ONE_Q60_L - h));
		z = 0;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += longint'(hvd_pkg::ATAN_TAB[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(hvd_pkg::ATAN_TAB[i]);
			end
		end
		if (z < 0) z = 0;
		d = (z * SCALE_L + (64'sd1 << 35)) >>> 36;
		if (d > DMAX_L) d = DMAX_L;
		return d[24:0];
	endfunction

	class distance_board;
		logic [24:0] due_q[$];
		int          mismatches;

		function new();
			mismatches = 0;
		endfunction

		function void note_pair(input logic [127:0] pair);
			due_q.push_back(great_circle_m(pair));
		endfunction

		function void check_distance(input logic [31:0] got);
			logic [24:0] want;
			if (due_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %0d", got);
				return;
			end
			want = due_q.pop_front();
			if (got !== {7'd0, want}) begin
				mismatches++;
				if (mismatches <= 10)
					$display("distance mismatch: expected %0d, got %0d", want, got);
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	distance_board board;
	int  idle_cycles;
	bit  long_hold_req;
	int  hold_left;
	int  rx_cycle;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// Watchdog: count cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: check each transfer and stall on its own pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) board.check_distance(m_axis_tdata);
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 0;
				hold_left = 400;
				m_axis_tready <= 1'b0;
			end else if ((rx_cycle / 53) % 3 == 1) begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end else if ((rx_cycle / 53) % 3 == 2) begin
				m_axis_tready <= ($urandom_range(0, 1) != 0);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic logic [127:0] pack_pair(input logic [30:0] la, input logic [31:0] lo,
			input logic [30:0] lb, input logic [31:0] lob);
		return {2'b00, lob, lb, lo, la};
	endfunction

	// Offer one pair and hold it until the transfer
	task automatic send_pair(input logic [127:0] pair);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pair;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_pair(pair);
	endtask

	// Drop valid for a gap given by n; a zero-length gap leaves valid alone
	task automatic pause_sender(input int n);
		if (n == 0) return;
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [30:0] rand_lat(input bit wide);
		if (wide) return 31'($urandom);
		return 31'($signed($urandom_range(0, 1800000000)) - 32'sd900000000);
	endfunction

	function automatic logic [31:0] rand_lon(input bit wide);
		if (wide) return $urandom;
		return 32'($signed($urandom_range(0, 3600000000)) - 33'sd1800000000);
	endfunction

	logic [127:0] directed_q[$];
	int burst_left;

	initial begin
		board = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		idle_cycles   = 0;
		long_hold_req = 0;
		hold_left     = 0;
		rx_cycle      = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes, identical points, antipodes, latitudes past the poles, longitude wrap
		directed_q.push_back(pack_pair(31'd0, 32'd0, 31'd0, 32'd0));
		directed_q.push_back(pack_pair(31'sd900000000, 32'd0, -31'sd900000000, 32'd0));
		directed_q.push_back(pack_pair(31'd0, 32'd0, 31'd0, 32'sd1800000000));
		directed_q.push_back(pack_pair(31'd0, -32'sd1800000000, 31'd0, 32'sd1800000000));
		directed_q.push_back(pack_pair(31'sd450000000, 32'sd100000000,
			-31'sd450000000, -32'sd1700000000));
		directed_q.push_back(pack_pair(31'sd900000000, 32'sd1800000000,
			31'sd900000000, -32'sd1800000000));
		directed_q.push_back(pack_pair(-31'sd900000000, 32'd0, -31'sd900000000, 32'sd900000000));
		directed_q.push_back(pack_pair(31'h3FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 32'h80000000));
		directed_q.push_back(pack_pair(31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF));
		directed_q.push_back(pack_pair(31'h7FFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF));
		directed_q.push_back(pack_pair(31'sd1000000000, 32'd0, 31'sd1000000000, 32'sd1800000000));
		directed_q.push_back(pack_pair(31'd1, 32'd0, 31'd0, 32'd1));
		directed_q.push_back(pack_pair(31'sd400000000, 32'sd20000000,
			31'sd400000010, 32'sd20000010));
		directed_q.push_back(pack_pair(31'd0, 32'sd1799999999, 31'd0, -32'sd1799999999));
		directed_q.push_back(pack_pair(31'sd899999999, 32'd0, -31'sd899999999, 32'sd1800000000));
		directed_q.push_back(pack_pair(31'sd123456789, -32'sd987654321,
			-31'sd234567891, 32'sd876543219));
		foreach (directed_q[k]) send_pair(directed_q[k]);
		pause_sender(3);

		// Random bursts; mostly in-range points, some using every bit of the fields
		burst_left = 0;
		for (int n = 0; n < 950; n++) begin
			bit wide;
			if (n == 300) long_hold_req = 1;
			if (n == 600) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (board.pending() != 0) @(posedge clk);
			end
			wide = ($urandom_range(0, 9) < 3);
			send_pair(pack_pair(rand_lat(wide), rand_lon(wide), rand_lat(wide), rand_lon(wide)));
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if (n < 200 || n > 450) pause_sender($urandom_range(0, 8));
			end else begin
				burst_left--;
			end
		end
		s_axis_tvalid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/hvd_pkg.sv
sv/haversine_distance_unit.sv
verif/testbench.sv
